/* rtl/oih_pkg.sv */
// ----------------------------------------------------------------------------
// oih_pkg
// Shared types, constants and tables for the orientation integral histogram.
// ----------------------------------------------------------------------------
package oih_pkg;

  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned MaxTotalBins = 16;
  localparam int unsigned CordicSteps  = 20;
  localparam int unsigned TurnBits     = 24;
  localparam int unsigned ValW         = 44;
  localparam logic [ValW-1:0] Sat44    = {ValW{1'b1}};

  localparam logic [10:0] RstImageWidth = 11'd640;
  localparam logic [3:0]  RstNumBins    = 4'd9;
  localparam logic [15:0] RstZeroThr    = 16'd3;

  typedef enum logic [2:0] {
    RegImageWidth = 3'd0,
    RegNumBins    = 3'd1,
    RegUseZeroBin = 3'd2,
    RegFullCircle = 3'd3,
    RegZeroThr    = 3'd4,
    RegUseWeight  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic [16:0]        pixel_weight;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    logic [3:0]      bin_index;
    logic [ValW-1:0] integral_value;
    logic            last_bin;
  } out_item_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [3:0]  num_bins;
    logic        use_zero_bin;
    logic        full_circle;
    logic [15:0] zero_threshold;
    logic        use_weight;
  } cfg_t;

  // one pixel's vote, handed from front to back
  typedef struct packed {
    logic        frame_start;
    logic [3:0]  lo_bin;
    logic [39:0] lo_vote;
    logic [39:0] hi_vote;
    logic        two;
  } vote_t;

  function automatic logic [TurnBits-1:0] atan_tab(input logic [4:0] i);
    case (i)
      5'd0:  atan_tab = 24'd2097152;
      5'd1:  atan_tab = 24'd1238021;
      5'd2:  atan_tab = 24'd654136;
      5'd3:  atan_tab = 24'd332050;
      5'd4:  atan_tab = 24'd166669;
      5'd5:  atan_tab = 24'd83416;
      5'd6:  atan_tab = 24'd41718;
      5'd7:  atan_tab = 24'd20860;
      5'd8:  atan_tab = 24'd10430;
      5'd9:  atan_tab = 24'd5215;
      5'd10: atan_tab = 24'd2608;
      5'd11: atan_tab = 24'd1304;
      5'd12: atan_tab = 24'd652;
      5'd13: atan_tab = 24'd326;
      5'd14: atan_tab = 24'd163;
      5'd15: atan_tab = 24'd81;
      5'd16: atan_tab = 24'd41;
      5'd17: atan_tab = 24'd20;
      5'd18: atan_tab = 24'd10;
      5'd19: atan_tab = 24'd5;
      default: atan_tab = 24'd0;
    endcase
  endfunction

endpackage

/* rtl/oih_front.sv */
// ----------------------------------------------------------------------------
// oih_front
// Magnitude, weighting, angle and bin split for one pixel; iterative units.
// ----------------------------------------------------------------------------
module oih_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oih_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  oih_pkg::in_item_t in_data_i,
  output logic              v_valid_o,
  input  logic              v_stall_i,
  output oih_pkg::vote_t    v_data_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_MULW, S_CORD, S_ANG, S_SPLIT, S_MULH, S_OUT
  } state_e;

  state_e state_q;
  oih_pkg::in_item_t it_q;
  logic [41:0] rad_q;
  logic [41:0] res_q;
  logic [5:0]  sc_q;
  logic [39:0] magw_q;
  logic signed [40:0] x_q, y_q;
  logic signed [26:0] z_q;
  logic [4:0]  ci_q;
  logic        swap_q;
  logic [23:0] ang_q;
  logic [16:0] wh_q;
  logic [3:0]  lo_q;
  oih_pkg::vote_t w_q;
  oih_pkg::vote_t v_q;
  logic        vv_q;

  logic [16:0] ax, ay;
  logic signed [40:0] dx, dy;
  logic [16:0] wsel;
  logic [3:0]  nb;
  logic        fc;
  logic [41:0] trial;
  logic signed [26:0] zc;
  logic [23:0] t, angf;
  logic [28:0] s_full;
  logic [24:0] rsz;
  logic signed [29:0] s;
  logic [3:0]  lower;
  logic [24:0] rem_sh;
  logic [56:0] hiprod;

  assign ax = it_q.grad_x[15] ? 17'(-$signed({it_q.grad_x[15], it_q.grad_x}))
                              : {1'b0, it_q.grad_x};
  assign ay = it_q.grad_y[15] ? 17'(-$signed({it_q.grad_y[15], it_q.grad_y}))
                              : {1'b0, it_q.grad_y};
  assign nb = (cfg_i.num_bins == 4'd0) ? 4'd1 : cfg_i.num_bins;
  assign fc = cfg_i.full_circle;
  assign wsel = (!cfg_i.use_weight || it_q.pixel_weight > 17'd65536) ? 17'd65536
                                                                     : it_q.pixel_weight;
  assign trial = res_q + (42'd1 << sc_q);
  assign dx = y_q >>> ci_q;
  assign dy = x_q >>> ci_q;
  assign zc = (z_q < 0) ? 27'sd0 : ((z_q > 27'sd2097152) ? 27'sd2097152 : z_q);
  assign t = swap_q ? 24'(24'd4194304 - 24'(zc)) : 24'(zc);
  always_comb begin
    if (!it_q.grad_x[15]) angf = it_q.grad_y[15] ? 24'(25'd16777216 - 25'(t)) : t;
    else angf = it_q.grad_y[15] ? 24'(24'd8388608 + t) : 24'(24'd8388608 - t);
  end
  assign rsz = fc ? 25'd16777216 : 25'd8388608;
  assign s_full = 29'(ang_q) * 29'(nb);
  assign s = $signed({1'b0, s_full}) - $signed({5'b0, rsz >> 1});
  always_comb begin
    lower = 4'd0;
    rem_sh = 25'(s);
    for (int k = 1; k < 16; k++) begin
      if (30'(s) >= 30'(k) * 30'(rsz)) begin
        lower = 4'(k);
        rem_sh = 25'(30'(s) - 30'(k) * 30'(rsz));
      end
    end
  end
  assign hiprod = 57'(magw_q) * 57'(wh_q);

  assign in_stall_o = (state_q != S_IDLE);
  assign v_valid_o  = vv_q;
  assign v_data_o   = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vv_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            it_q    <= in_data_i;
            state_q <= S_SQRT;
            res_q   <= '0;
            sc_q    <= 6'd40;
            rad_q   <= 42'(({17'd0, in_data_i.grad_x[15] ?
                        17'(-$signed({in_data_i.grad_x[15], in_data_i.grad_x})) :
                        {1'b0, in_data_i.grad_x}} ** 2)
                       + ({17'd0, in_data_i.grad_y[15] ?
                        17'(-$signed({in_data_i.grad_y[15], in_data_i.grad_y})) :
                        {1'b0, in_data_i.grad_y}} ** 2)) << 8;
          end
        end
        S_SQRT: begin
          if (trial <= rad_q) begin
            rad_q <= rad_q - trial;
            res_q <= (res_q >> 1) + (42'd1 << sc_q);
          end else begin
            res_q <= res_q >> 1;
          end
          if (sc_q == 6'd0) state_q <= S_MULW;
          else sc_q <= sc_q - 6'd2;
        end
        S_MULW: begin
          magw_q  <= 40'((38'(res_q[20:0]) * 38'(wsel)) >> 16);
          swap_q  <= (ay > ax);
          x_q     <= (ay > ax) ? 41'(ay) <<< 20 : 41'(ax) <<< 20;
          y_q     <= (ay > ax) ? 41'(ax) <<< 20 : 41'(ay) <<< 20;
          z_q     <= '0;
          ci_q    <= '0;
          state_q <= S_CORD;
        end
        S_CORD: begin
          if (cfg_i.use_zero_bin && magw_q < 40'(cfg_i.zero_threshold)) begin
            w_q <= '{frame_start: it_q.frame_start, lo_bin: nb, lo_vote: 40'd16,
                     hi_vote: 40'd0, two: 1'b0};
            state_q <= S_OUT;
          end else begin
            if (y_q >= 0) begin
              x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + 27'(oih_pkg::atan_tab(ci_q));
            end else begin
              x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - 27'(oih_pkg::atan_tab(ci_q));
            end
            if (ci_q == 5'(oih_pkg::CordicSteps - 1)) state_q <= S_ANG;
            else ci_q <= ci_q + 5'd1;
          end
        end
        S_ANG: begin
          if (ax == 17'd0 && ay == 17'd0) ang_q <= '0;
          else if (!fc && angf > 24'd8388608) ang_q <= angf - 24'd8388608;
          else ang_q <= angf;
          state_q <= S_SPLIT;
        end
        S_SPLIT: begin
          w_q.frame_start <= it_q.frame_start;
          if (s <= 0) begin
            w_q.lo_bin <= 4'd0; w_q.lo_vote <= magw_q >> 4; w_q.two <= 1'b0;
            w_q.hi_vote <= '0;
            state_q <= S_OUT;
          end else if (lower >= nb - 4'd1) begin
            w_q.lo_bin <= nb - 4'd1; w_q.lo_vote <= magw_q >> 4; w_q.two <= 1'b0;
            w_q.hi_vote <= '0;
            state_q <= S_OUT;
          end else begin
            lo_q <= lower;
            // frac*2^16/rsz, rsz being a power of two
            wh_q <= fc ? 17'(rem_sh >> 8) : 17'(rem_sh >> 7);
            state_q <= S_MULH;
          end
        end
        S_MULH: begin
          w_q.lo_bin  <= lo_q;
          w_q.hi_vote <= 40'(hiprod >> 20);
          w_q.lo_vote <= (magw_q >> 4) - 40'(hiprod >> 20);
          w_q.two     <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (!vv_q || !v_stall_i) begin
            v_q     <= w_q;
            vv_q    <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (vv_q && !v_stall_i && !(state_q == S_OUT)) vv_q <= 1'b0;
    end
  end

endmodule

/* rtl/oih_back.sv */
// ----------------------------------------------------------------------------
// oih_back
// Row running sums, column line buffer and per-bin result emission.
// ----------------------------------------------------------------------------
module oih_back #(
  parameter int unsigned MAX_WIDTH = oih_pkg::MaxWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  oih_pkg::cfg_t      cfg_i,
  input  logic               v_valid_i,
  output logic               v_stall_o,
  input  oih_pkg::vote_t     v_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output oih_pkg::out_item_t out_data_o
);

  localparam int unsigned NB = oih_pkg::MaxTotalBins;
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned BW = $clog2(NB);
  localparam int unsigned AW = CW + BW;
  localparam int unsigned VW = oih_pkg::ValW;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_EMIT} state_e;

  state_e state_q;
  logic [VW-1:0] rsum_q [NB];
  logic [VW-1:0] lb_mem [2**AW];
  logic [VW-1:0] lb_rd_q;
  logic [CW:0]   col_q;
  logic          first_q;
  oih_pkg::vote_t v_q;
  logic [BW-1:0] b_q;
  logic          ov_q;
  oih_pkg::out_item_t od_q;

  logic [3:0]  nb;
  logic [BW:0] total;
  logic [12:0] width;
  logic [VW-1:0] vote, rs_new, acc;
  logic [VW:0] s1, s2;
  logic [AW-1:0] addr;
  logic [CW-1:0] col;
  logic          last_b, row_end;

  assign nb    = (cfg_i.num_bins == 4'd0) ? 4'd1 : cfg_i.num_bins;
  assign total = (BW+1)'(nb) + (BW+1)'(cfg_i.use_zero_bin);
  assign width = (cfg_i.image_width == 11'd0) ? 13'd1 :
                 ((13'(cfg_i.image_width) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH)
                                                            : 13'(cfg_i.image_width));
  assign col  = (col_q >= (CW+1)'(MAX_WIDTH)) ? '0 : col_q[CW-1:0];
  assign addr = {col, b_q};
  always_comb begin
    vote = '0;
    if (4'(b_q) == v_q.lo_bin) vote = VW'(v_q.lo_vote);
    else if (v_q.two && 4'(b_q) == v_q.lo_bin + 4'd1) vote = VW'(v_q.hi_vote);
  end
  assign s1 = {1'b0, rsum_q[b_q]} + {1'b0, vote};
  assign rs_new = s1[VW] ? oih_pkg::Sat44 : s1[VW-1:0];
  assign s2 = {1'b0, lb_rd_q} + {1'b0, rs_new};
  assign acc = first_q ? rs_new : (s2[VW] ? oih_pkg::Sat44 : s2[VW-1:0]);
  assign last_b  = ((BW+1)'(b_q) == total - 1'b1);
  assign row_end = (13'(col) + 13'd1 >= width);

  assign v_stall_o   = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && (!ov_q || !out_stall_i)) lb_mem[addr] <= acc;
    lb_rd_q <= lb_mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      col_q   <= '0;
      first_q <= 1'b1;
      b_q     <= '0;
      for (int k = 0; k < NB; k++) rsum_q[k] <= '0;
    end else begin
      if (ov_q && !out_stall_i && !(state_q == S_EMIT)) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (v_valid_i) begin
            v_q <= v_data_i;
            b_q <= '0;
            if (v_data_i.frame_start) begin
              col_q   <= '0;
              first_q <= 1'b1;
              for (int k = 0; k < NB; k++) rsum_q[k] <= '0;
            end
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_EMIT;
        S_EMIT: begin
          if (!ov_q || !out_stall_i) begin
            ov_q <= 1'b1;
            od_q.bin_index      <= 4'(b_q);
            od_q.integral_value <= acc;
            od_q.last_bin       <= last_b;
            if (last_b && row_end) begin
              for (int k = 0; k < NB; k++) rsum_q[k] <= '0;
            end else begin
              rsum_q[b_q] <= rs_new;
            end
            if (last_b) begin
              state_q <= S_IDLE;
              if (row_end) begin
                col_q   <= '0;
                first_q <= 1'b0;
              end else begin
                col_q <= (CW+1)'(col) + 1'b1;
              end
            end else begin
              b_q     <= b_q + 1'b1;
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/oih_cfg.sv */
// ----------------------------------------------------------------------------
// oih_cfg
// APB register file for the histogram configuration.
// ----------------------------------------------------------------------------
module oih_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output oih_pkg::cfg_t cfg_o
);

  oih_pkg::cfg_t cfg_q;
  oih_pkg::reg_idx_e idx;

  assign idx    = oih_pkg::reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    unique case (idx)
      oih_pkg::RegImageWidth: prdata = 32'(cfg_q.image_width);
      oih_pkg::RegNumBins:    prdata = 32'(cfg_q.num_bins);
      oih_pkg::RegUseZeroBin: prdata = 32'(cfg_q.use_zero_bin);
      oih_pkg::RegFullCircle: prdata = 32'(cfg_q.full_circle);
      oih_pkg::RegZeroThr:    prdata = 32'(cfg_q.zero_threshold);
      oih_pkg::RegUseWeight:  prdata = 32'(cfg_q.use_weight);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{image_width: oih_pkg::RstImageWidth, num_bins: oih_pkg::RstNumBins,
                 use_zero_bin: 1'b0, full_circle: 1'b0,
                 zero_threshold: oih_pkg::RstZeroThr, use_weight: 1'b0};
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        oih_pkg::RegImageWidth: cfg_q.image_width    <= pwdata[10:0];
        oih_pkg::RegNumBins:    cfg_q.num_bins       <= pwdata[3:0];
        oih_pkg::RegUseZeroBin: cfg_q.use_zero_bin   <= pwdata[0];
        oih_pkg::RegFullCircle: cfg_q.full_circle    <= pwdata[0];
        oih_pkg::RegZeroThr:    cfg_q.zero_threshold <= pwdata[15:0];
        oih_pkg::RegUseWeight:  cfg_q.use_weight     <= pwdata[0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/orientation_integral_histogram_unit.sv */
// ----------------------------------------------------------------------------
// orientation_integral_histogram_unit
// Streaming integral histogram of oriented gradients.
// ----------------------------------------------------------------------------
// Usage: pixels enter in raster order on in_valid_i/in_stall_o carrying
// gradients, weight and a frame_start mark. For each pixel one transaction
// per bin leaves on out_valid_o/out_stall_i, bins in ascending order, the
// zero bin last when enabled; last_bin flags the final one.
// Configuration goes through the APB port; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Sequence: the front takes a split pixel through a 21-step square root,
// a 20-step CORDIC, angle, split, product and hand-off; a one-bin pixel
// skips the product and a zero-bin pixel skips CORDIC, angle and split.
// The back accepts a pixel, then per bin reads and updates the line
// buffer; neither part takes a new pixel before it is through with the last.
// A one-entry register between front and back lets each stall on its own;
// a stalled output holds its transaction and backs up both parts.
// Reset clears control state, row sums and registers to their defaults;
// the line buffer is undefined until written by the first row.
// ----------------------------------------------------------------------------
module orientation_integral_histogram_unit #(
  parameter int unsigned MAX_WIDTH = oih_pkg::MaxWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  oih_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output oih_pkg::out_item_t out_data_o
);

  oih_pkg::cfg_t  cfg;
  oih_pkg::vote_t vd;
  logic           vv, vs;

  oih_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  oih_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_valid_i, .in_stall_o, .in_data_i,
    .v_valid_o(vv), .v_stall_i(vs), .v_data_o(vd)
  );

  oih_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .v_valid_i(vv), .v_stall_o(vs), .v_data_i(vd),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

/* tb/tb_orientation_integral_histogram_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_orientation_integral_histogram_unit
// Self-checking bench for the streaming integral histogram of gradients.
// Pixels go in with random gaps, bin transactions come out under random
// stall. A local model predicts every bin transaction; checks cover extreme
// gradients and weights, the zero bin, degenerate widths and bin counts,
// a width drop inside a row and random frames over many register settings.
// ----------------------------------------------------------------------------
module tb_orientation_integral_histogram_unit;

  localparam longint unsigned SatVal    = 64'h0000_0FFF_FFFF_FFFF;
  localparam longint          FullTurn  = 64'd16777216;
  localparam int              WdogLimit = 4000;
  localparam longint          AtanStep[20] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860, 10430, 5215,
    2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  oih_pkg::in_item_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  oih_pkg::out_item_t out_data;

  orientation_integral_histogram_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  // model state
  oih_pkg::cfg_t   cfg;
  longint unsigned row_sum[16];
  logic [43:0]     col_buf[16384];
  bit              col_buf_ok[16384];
  int unsigned     col_cnt;
  bit              top_row;

  oih_pkg::out_item_t pending_bins[$];
  int              errors = 0;
  int              pixels_sent = 0;
  int              bins_seen = 0;
  bit              no_idle = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report(string what, longint unsigned got, longint unsigned exp);
    $display("MISMATCH %s: got %0d expected %0d (bins seen %0d)", what, got, exp, bins_seen);
    errors++;
  endtask

  function automatic longint unsigned sat44(longint unsigned v);
    return (v > SatVal) ? SatVal : v;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned root = 0;
    longint unsigned bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint octant_turns(longint a, longint b);
    longint x, y, z, dx, dy;
    x = a * 1048576;
    y = b * 1048576;
    z = 0;
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += AtanStep[i];
      end else begin
        x -= dx; y += dy; z -= AtanStep[i];
      end
    end
    if (z < 0) z = 0;
    if (z > FullTurn / 8) z = FullTurn / 8;
    return z;
  endfunction

  function automatic longint grad_angle(longint x, longint y);
    longint ax, ay, t, ang;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    if (ax == 0 && ay == 0) return 0;
    if (ay <= ax) t = octant_turns(ax, ay);
    else t = FullTurn / 4 - octant_turns(ay, ax);
    if (x >= 0) ang = (y >= 0) ? t : FullTurn - t;
    else ang = (y >= 0) ? FullTurn / 2 - t : FullTurn / 2 + t;
    return ang & (FullTurn - 1);
  endfunction

  // Forces a frame start where the pixel would read a never-written column entry.
  task automatic predict_bins(inout oih_pkg::in_item_t px);
    int unsigned     wdt, nb, total, col, idx;
    longint          gx, gy, ang, rsz, s, lower, frac;
    longint unsigned w, mag, magw, wh, hi;
    longint unsigned vote[16];
    longint unsigned acc;
    oih_pkg::out_item_t r;
    wdt = cfg.image_width;
    if (wdt == 0) wdt = 1;
    if (wdt > 1024) wdt = 1024;
    nb = (cfg.num_bins == 0) ? 1 : cfg.num_bins;
    total = nb + cfg.use_zero_bin;
    if (!px.frame_start && !top_row) begin
      col = (col_cnt >= 1024) ? 0 : col_cnt;
      for (int b = 0; b < total; b++)
        if (!col_buf_ok[col * 16 + b]) px.frame_start = 1'b1;
    end
    if (px.frame_start) begin
      col_cnt = 0;
      top_row = 1'b1;
      foreach (row_sum[i]) row_sum[i] = 0;
    end
    col = (col_cnt >= 1024) ? 0 : col_cnt;
    gx = $signed(px.grad_x);
    gy = $signed(px.grad_y);
    w = px.pixel_weight;
    if (!cfg.use_weight || w > 65536) w = 65536;
    mag = sqrt_floor(longint'(gx * gx + gy * gy) * 256);
    magw = (mag * w) >> 16;
    foreach (vote[i]) vote[i] = 0;
    if (cfg.use_zero_bin && magw < cfg.zero_threshold) begin
      vote[nb] = 16;
    end else begin
      ang = grad_angle(gx, gy);
      rsz = cfg.full_circle ? FullTurn : FullTurn / 2;
      if (!cfg.full_circle && ang > FullTurn / 2) ang -= FullTurn / 2;
      s = ang * longint'(nb) - rsz / 2;
      if (s <= 0) begin
        vote[0] = magw >> 4;
      end else begin
        lower = s / rsz;
        frac = s % rsz;
        if (lower >= longint'(nb) - 1) begin
          vote[nb-1] = magw >> 4;
        end else begin
          wh = (64'(frac) << 16) / 64'(rsz);
          hi = (magw * wh) >> 20;
          vote[lower+1] = hi;
          vote[lower] = (magw >> 4) - hi;
        end
      end
    end
    for (int b = 0; b < total; b++) begin
      idx = col * 16 + b;
      row_sum[b] = sat44(row_sum[b] + vote[b]);
      acc = top_row ? row_sum[b] : sat44(64'(col_buf[idx]) + row_sum[b]);
      col_buf[idx] = acc[43:0];
      col_buf_ok[idx] = 1'b1;
      r.bin_index = b[3:0];
      r.integral_value = acc[43:0];
      r.last_bin = (b == total - 1);
      pending_bins.insert(pending_bins.size(), r);
    end
    if (col + 1 >= wdt) begin
      col_cnt = 0;
      top_row = 1'b0;
      foreach (row_sum[i]) row_sum[i] = 0;
    end else begin
      col_cnt = col + 1;
    end
  endtask

  task automatic send_pixel(oih_pkg::in_item_t px);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    predict_bins(px);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic send_grad(int gx, int gy, int w, bit fs);
    oih_pkg::in_item_t px;
    px.grad_x = gx[15:0];
    px.grad_y = gy[15:0];
    px.pixel_weight = w[16:0];
    px.frame_start = fs;
    send_pixel(px);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(oih_pkg::reg_idx_e ri, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {ri, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (ri)
      oih_pkg::RegImageWidth: cfg.image_width = val[10:0];
      oih_pkg::RegNumBins:    cfg.num_bins = val[3:0];
      oih_pkg::RegUseZeroBin: cfg.use_zero_bin = val[0];
      oih_pkg::RegFullCircle: cfg.full_circle = val[0];
      oih_pkg::RegZeroThr:    cfg.zero_threshold = val[15:0];
      oih_pkg::RegUseWeight:  cfg.use_weight = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all(int wdt, int nb, bit zb, bit fc, int thr, bit uw);
    drain();
    write_reg(oih_pkg::RegImageWidth, wdt);
    write_reg(oih_pkg::RegNumBins, nb);
    write_reg(oih_pkg::RegUseZeroBin, 32'(zb));
    write_reg(oih_pkg::RegFullCircle, 32'(fc));
    write_reg(oih_pkg::RegZeroThr, thr);
    write_reg(oih_pkg::RegUseWeight, 32'(uw));
  endtask

  // defaults after reset, first pixel without a frame mark
  task automatic test_reset_defaults();
    send_grad(160, 0, 0, 1'b0);
    send_grad(-50, 90, 0, 1'b0);
    send_grad(0, -77, 0, 1'b0);
  endtask

  task automatic test_extremes();
    write_all(4, 15, 1'b1, 1'b1, 3, 1'b1);
    send_grad(32767, 0, 65536, 1'b1);
    send_grad(-32768, 0, 65536, 1'b0);
    send_grad(0, 32767, 131071, 1'b0);
    send_grad(0, -32768, 0, 1'b0);
    send_grad(0, 0, 65536, 1'b0);
    send_grad(-32768, -32768, 65536, 1'b0);
    send_grad(32767, 32767, 1, 1'b0);
    send_grad(1, -1, 65536, 1'b0);
    send_grad(-32768, 32767, 98304, 1'b0);
    write_all(3, 1, 1'b0, 1'b0, 65535, 1'b0);
    send_grad(-32768, -1, 0, 1'b1);
    send_grad(5, 32767, 0, 1'b0);
    send_grad(0, 0, 0, 1'b0);
  endtask

  task automatic test_degenerate_cfg();
    write_all(0, 0, 1'b1, 1'b0, 65535, 1'b0);
    send_grad(300, 300, 0, 1'b1);
    send_grad(-300, 20, 0, 1'b0);
    send_grad(0, 0, 0, 1'b0);
    write_all(2047, 15, 1'b0, 1'b1, 0, 1'b1);
    send_grad(1000, -1000, 65535, 1'b1);
    send_grad(-7, 3, 131071, 1'b0);
  endtask

  task automatic test_width_drop();
    write_all(8, 6, 1'b1, 1'b0, 40, 1'b0);
    for (int i = 0; i < 5; i++) send_grad(i * 70 - 100, 200 - i * 90, 0, i == 0);
    write_all(3, 6, 1'b1, 1'b0, 40, 1'b0);
    for (int i = 0; i < 6; i++) send_grad(i * 33 - 90, i * 41, 0, 1'b0);
  endtask

  function automatic int rand_grad();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 8) - 4;
      1: return $signed(16'($urandom()));
      default: return $urandom_range(0, 4000) - 2000;
    endcase
  endfunction

  task automatic test_random_frames();
    int wdt, nb;
    for (int ph = 0; ph < 8; ph++) begin
      wdt = (ph == 0) ? 1 : (ph == 1) ? 1024 : $urandom_range(1, 12);
      nb = (ph == 0) ? 15 : (ph == 1) ? 1 : $urandom_range(0, 15);
      write_all(wdt, nb, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                (ph == 2) ? 65535 : (ph == 3) ? 0 : $urandom_range(0, 600),
                1'($urandom_range(0, 1)));
      no_idle = (ph == 4);
      for (int i = 0; i < 10; i++) begin
        if (ph == 5 && i == 7) begin
          in_valid <= 1'b0;
          while (pending_bins.size() != 0) @(posedge clk);
        end
        send_grad(rand_grad(), rand_grad(), $urandom_range(0, 131071),
                  i == 0 || $urandom_range(0, 15) == 0);
      end
    end
    no_idle = 1'b0;
  endtask

  // output stall pattern
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // result checker
  always @(posedge clk) begin
    oih_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      bins_seen++;
      if (pending_bins.size() == 0) begin
        report("unexpected transaction, bin", out_data.bin_index, 0);
      end else begin
        want = pending_bins.pop_front();
        if (out_data.bin_index != want.bin_index)
          report("bin_index", out_data.bin_index, want.bin_index);
        if (out_data.integral_value != want.integral_value)
          report("integral_value", out_data.integral_value, want.integral_value);
        if (out_data.last_bin != want.last_bin)
          report("last_bin", out_data.last_bin, want.last_bin);
      end
    end
  end

  // watchdog
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WdogLimit) begin
        $display("Timeout: no transaction for %0d cycles", WdogLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    cfg.image_width = oih_pkg::RstImageWidth;
    cfg.num_bins = oih_pkg::RstNumBins;
    cfg.use_zero_bin = 1'b0;
    cfg.full_circle = 1'b0;
    cfg.zero_threshold = oih_pkg::RstZeroThr;
    cfg.use_weight = 1'b0;
    foreach (row_sum[i]) row_sum[i] = 0;
    col_cnt = 0;
    top_row = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_degenerate_cfg();
    test_width_drop();
    test_random_frames();
    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (pending_bins.size() != 0) report("transactions still outstanding", 0, pending_bins.size());
    $display("Covered %0d pixels and %0d bin transactions over extreme, degenerate",
             pixels_sent, bins_seen);
    $display("and random register settings, %0d mismatches", errors);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
rtl/oih_pkg.sv
rtl/oih_front.sv
rtl/oih_back.sv
rtl/oih_cfg.sv
rtl/orientation_integral_histogram_unit.sv
tb/tb_orientation_integral_histogram_unit.sv
